// ----- hw/rtl/nspc_pkg.sv -----
`timescale 1ns / 1ps

package nspc_pkg;

    // Default sizes, handed to the top level parameters
    localparam int NUM_SECTIONS_DEF = 256;
    localparam int STACK_DEPTH_DEF  = 16;

    // Section index field is 8 bits wide on the input stream
    localparam int SEC_IDX_W     = 8;
    localparam int SEC_IDX_RANGE = 1 << SEC_IDX_W;

    // Stream payload widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 232;

    // Event kinds carried in the input tuser
    typedef enum logic [1:0] {
        KIND_ENTER = 2'd0,
        KIND_EXIT  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESULT,
        ST_ENTER,
        ST_FRAME,
        ST_PARENT,
        ST_SECTION
    } state_t;

    // One row of the counter table, one row per section
    typedef struct packed {
        logic [63:0] excl;
        logic [63:0] incl;
        logic [31:0] hits;
        logic [63:0] bytes;
    } row_t;

    // One open frame on the section stack
    typedef struct packed {
        logic [SEC_IDX_W-1:0] parent;
        logic [SEC_IDX_W-1:0] section;
        logic [63:0]          enter_time;
        logic [63:0]          saved_incl;
    } frame_t;

endpackage

// ----- hw/rtl/nspc_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one read port, registered read
module nspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/nested_section_profile_counters.sv -----
`timescale 1ns / 1ps

// Nested section profiler. Enter, exit and read events arrive on the slave
// stream; each gives exactly one result transaction with the counters of one
// section. All per-section counters sit in one row-per-section table RAM, and
// the open frames in a stack RAM; enters and good exits are read-modify-writes
// on them. After reset the table is swept to zero, one row a cycle, and
// s_axis_tready stays low until the sweep is done. A read or rejected event
// does a table read, then its result; an enter a table read, then write and
// result; a good exit a stack read, parent row read, parent write with
// section row read, then section write and result. A new event is taken
// while the previous result still waits in the output register.
module nested_section_profile_counters
    import nspc_pkg::*;
#(
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF,
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // section_index[7:0], byte_count[39:8], timestamp[103:40]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_section[7:0], hit_total[39:8], exclusive_ticks[103:40],
    // inclusive_ticks[167:104], bytes_total[231:168]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]            m_axis_tuser
);

    localparam int SEC_W  = $clog2(NUM_SECTIONS);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ROW_W  = $bits(row_t);
    localparam int FRM_W  = $bits(frame_t);

    // Input fields
    logic [SEC_IDX_W-1:0] in_sec_raw;
    logic [31:0]          in_bytes;
    logic [63:0]          in_time;
    kind_t                in_kind;

    assign in_sec_raw = s_axis_tdata[7:0];
    assign in_bytes   = s_axis_tdata[39:8];
    assign in_time    = s_axis_tdata[103:40];
    assign in_kind    = kind_t'(s_axis_tuser);

    // Section index reduced modulo NUM_SECTIONS, constant table
    logic [SEC_W-1:0] sec_map [SEC_IDX_RANGE];
    for (genvar g = 0; g < SEC_IDX_RANGE; g++)
    begin : g_map
        assign sec_map[g] = SEC_W'(g % NUM_SECTIONS);
    end

    logic [SEC_W-1:0] in_sec;
    assign in_sec = sec_map[in_sec_raw];

    // Control registers
    state_t             state_reg, state_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [SEC_W-1:0]   active_reg, active_next;
    logic [SEC_W-1:0]   clr_reg, clr_next;
    logic               out_valid_reg;

    // Event payload registers
    logic [SEC_W-1:0]   sec_reg, sec_next;
    status_t            status_reg, status_next;
    logic [63:0]        time_reg, time_next;
    logic [31:0]        bytes_reg, bytes_next;
    logic [SEC_W-1:0]   parent_reg, parent_next;
    logic [SEC_W-1:0]   fsec_reg, fsec_next;
    logic [63:0]        saved_reg, saved_next;
    logic [63:0]        elapsed_reg, elapsed_next;
    logic [63:0]        par_excl_reg, par_excl_next;

    // Output registers
    logic [SEC_W-1:0]   out_sec_reg;
    status_t            out_status_reg;
    row_t               out_row_reg;

    // RAM ports
    logic               tbl_we;
    logic [SEC_W-1:0]   tbl_waddr;
    row_t               tbl_wdata;
    logic [SEC_W-1:0]   tbl_raddr;
    logic [ROW_W-1:0]   tbl_rdata;
    row_t               tbl_row;

    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    frame_t             stk_wdata;
    logic [STK_AW-1:0]  stk_raddr;
    logic [FRM_W-1:0]   stk_rdata;
    frame_t             stk_frame;

    assign tbl_row   = tbl_rdata;
    assign stk_frame = stk_rdata;

    // Result path
    logic               out_free;
    logic               out_load;
    row_t               res_row;
    logic [SEC_W-1:0]   res_sec;
    status_t            res_status;

    logic [LVL_W-1:0]   lvl_dec;
    logic [63:0]        sec_excl_base;
    row_t               upd_row;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign lvl_dec       = level_reg - LVL_W'(1);

    nspc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SECTIONS)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    nspc_ram #(
        .WIDTH (FRM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Section row on exit: parent write forwarded when recursing into itself
    always_comb
    begin
        sec_excl_base = (fsec_reg == parent_reg) ? par_excl_reg : tbl_row.excl;
        upd_row       = tbl_row;
        upd_row.excl  = sec_excl_base + elapsed_reg;
        upd_row.incl  = saved_reg + elapsed_reg;
        upd_row.hits  = (tbl_row.hits == '1) ? tbl_row.hits : tbl_row.hits + 32'd1;
    end

    // Sequencer: next state, RAM control and result selection
    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        active_next   = active_reg;
        clr_next      = clr_reg;
        sec_next      = sec_reg;
        status_next   = status_reg;
        time_next     = time_reg;
        bytes_next    = bytes_reg;
        parent_next   = parent_reg;
        fsec_next     = fsec_reg;
        saved_next    = saved_reg;
        elapsed_next  = elapsed_reg;
        par_excl_next = par_excl_reg;

        tbl_we        = 1'b0;
        tbl_waddr     = sec_reg;
        tbl_wdata     = tbl_row;
        tbl_raddr     = sec_reg;
        stk_we        = 1'b0;
        stk_waddr     = level_reg[STK_AW-1:0];
        stk_wdata     = '{parent:     SEC_IDX_W'(active_reg),
                          section:    SEC_IDX_W'(sec_reg),
                          enter_time: time_reg,
                          saved_incl: tbl_row.incl};
        stk_raddr     = lvl_dec[STK_AW-1:0];

        out_load      = 1'b0;
        res_row       = tbl_row;
        res_sec       = sec_reg;
        res_status    = status_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
                clr_next  = clr_reg + SEC_W'(1);
                if (clr_reg == SEC_W'(NUM_SECTIONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                tbl_raddr = in_sec;
                if (s_axis_tvalid)
                begin
                    time_next   = in_time;
                    bytes_next  = in_bytes;
                    sec_next    = in_sec;
                    status_next = STAT_OK;
                    case (in_kind)
                        KIND_ENTER:
                        begin
                            if (level_reg >= LVL_W'(STACK_DEPTH))
                            begin
                                status_next = STAT_OVERFLOW;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_ENTER;
                            end
                        end
                        KIND_EXIT:
                        begin
                            if (level_reg == '0)
                            begin
                                status_next = STAT_UNDERFLOW;
                                sec_next    = active_reg;
                                tbl_raddr   = active_reg;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                level_next = lvl_dec;
                                state_next = ST_FRAME;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // Read or rejected event: report the row as it stands
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // Enter: credit bytes, push the frame, make the section active
            ST_ENTER:
            begin
                res_row.bytes = tbl_row.bytes + {32'd0, bytes_reg};
                if (out_free)
                begin
                    tbl_we      = 1'b1;
                    tbl_wdata   = res_row;
                    stk_we      = 1'b1;
                    level_next  = level_reg + LVL_W'(1);
                    active_next = sec_reg;
                    out_load    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            // Exit: popped frame arrives, fetch the parent row
            ST_FRAME:
            begin
                parent_next  = SEC_W'(stk_frame.parent);
                fsec_next    = SEC_W'(stk_frame.section);
                saved_next   = stk_frame.saved_incl;
                elapsed_next = time_reg - stk_frame.enter_time;
                active_next  = SEC_W'(stk_frame.parent);
                tbl_raddr    = SEC_W'(stk_frame.parent);
                state_next   = ST_PARENT;
            end

            // Exit: charge elapsed against the parent, fetch the section row
            ST_PARENT:
            begin
                par_excl_next  = tbl_row.excl - elapsed_reg;
                tbl_we         = 1'b1;
                tbl_waddr      = parent_reg;
                tbl_wdata      = tbl_row;
                tbl_wdata.excl = par_excl_next;
                tbl_raddr      = fsec_reg;
                state_next     = ST_SECTION;
            end

            // Exit: update the section row and report it
            ST_SECTION:
            begin
                tbl_raddr = fsec_reg;
                res_row   = upd_row;
                res_sec   = fsec_reg;
                if (out_free)
                begin
                    tbl_we     = 1'b1;
                    tbl_waddr  = fsec_reg;
                    tbl_wdata  = upd_row;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            level_reg     <= '0;
            active_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            active_reg <= active_next;
            clr_reg    <= clr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Event payload and output holding registers
    always_ff @(posedge clk)
    begin
        sec_reg      <= sec_next;
        status_reg   <= status_next;
        time_reg     <= time_next;
        bytes_reg    <= bytes_next;
        parent_reg   <= parent_next;
        fsec_reg     <= fsec_next;
        saved_reg    <= saved_next;
        elapsed_reg  <= elapsed_next;
        par_excl_reg <= par_excl_next;
        if (out_load)
        begin
            out_sec_reg    <= res_sec;
            out_status_reg <= res_status;
            out_row_reg    <= res_row;
        end
    end

    // Output stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_row_reg.bytes,
                            out_row_reg.incl,
                            out_row_reg.excl,
                            out_row_reg.hits,
                            SEC_IDX_W'(out_sec_reg)};

endmodule

// ----- hw/rtl/nspc_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks: no result without an event, at most two events pending
module nspc_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Events taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // A result never appears without an event behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 2'd0))
        else $error("result transaction with no event pending");

    // At most one event in work plus one result held
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two events outstanding");

    // Ready for a new event only once the previous one left the work stage
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (pending_reg <= 2'd1))
        else $error("input ready while an event is still in work");

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

endmodule

bind nested_section_profile_counters nspc_checker u_nspc_checker (.*);
